// ----- rtl/ght_pkg.sv -----
// Shared types and constants for the generational handle table.
// Used by the interfaces, the step unit and the top level; depends on nothing.
package ght_pkg;

	localparam int KIND_W    = 2;
	localparam int IDX_W     = 6;
	localparam int GEN_W     = 16;
	localparam int CNT_W     = 16;
	localparam int PAY_W     = 32;
	localparam int ACT_W     = 6;
	localparam int STATUS_W  = 2;
	localparam int CFG_W     = 7;
	localparam int META_W    = GEN_W + CNT_W;
	localparam int SLOTS_DEF = 64;
	localparam int CAP_LIMIT = (2 ** CFG_W) - 1;

	localparam logic [CFG_W-1:0] CFG_RESET  = 7'd32;
	localparam logic [CFG_W-1:0] HINT_RESET = 7'd1;

	typedef enum logic [KIND_W-1:0] {
		KIND_CREATE  = 2'd0,
		KIND_ADD_REF = 2'd1,
		KIND_RELEASE = 2'd2,
		KIND_LOOKUP  = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK      = 2'd0,
		STATUS_INVALID = 2'd1,
		STATUS_FULL    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		STEP_PASS    = 2'd0,
		STEP_INC     = 2'd1,
		STEP_INC_SAT = 2'd2,
		STEP_DEC     = 2'd3
	} step_op_t;

	typedef struct packed {
		step_op_t         op;
		logic [CNT_W-1:0] a;
	} step_req_t;

	typedef struct packed {
		logic [CNT_W-1:0] y;
		logic             zero;
	} step_rsp_t;

endpackage

// ----- rtl/ght_if.sv -----
// Request and response channels of the handle table, valid/ready handshake.
// Field widths come from ght_pkg.
interface ght_req_if import ght_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [IDX_W-1:0]  handle_index;
	logic [GEN_W-1:0]  handle_generation;
	logic [PAY_W-1:0]  payload_id;

	modport source (output valid, kind, handle_index, handle_generation, payload_id,
		input ready);
	modport sink (input valid, kind, handle_index, handle_generation, payload_id,
		output ready);
endinterface

interface ght_rsp_if import ght_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [IDX_W-1:0]    result_index;
	logic [GEN_W-1:0]    result_generation;
	logic [CNT_W-1:0]    ref_count;
	logic [PAY_W-1:0]    payload_out;
	logic [ACT_W-1:0]    active_count;

	modport source (output valid, status, result_index, result_generation, ref_count,
		payload_out, active_count, input ready);
	modport sink (input valid, status, result_index, result_generation, ref_count,
		payload_out, active_count, output ready);
endinterface

// ----- rtl/ght_ram.sv -----
// Generic single-port RAM, one write or read per cycle, registered read data.
// No dependencies.
module ght_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/ght_step_unit.sv -----
// Shared increment, saturating increment and decrement unit of the sequencer.
// Depends on ght_pkg for the request and response types.
module ght_step_unit import ght_pkg::*; (
	input  step_req_t cmd,
	output step_rsp_t res
);

	logic [CNT_W-1:0] y;

	always_comb begin
		case (cmd.op)
			STEP_PASS:    y = cmd.a;
			STEP_INC:     y = cmd.a + CNT_W'(1);
			STEP_INC_SAT: y = (&cmd.a) ? cmd.a : cmd.a + CNT_W'(1);
			STEP_DEC:     y = cmd.a - CNT_W'(1);
			default:      y = cmd.a;
		endcase
	end

	assign res.y    = y;
	assign res.zero = (y == '0);

endmodule

// ----- rtl/generational_handle_table_unit.sv -----
// Generational handle table: reference-counted slots addressed by index and generation.
// Handle words: slot read (S_HRD), check (S_HCHK), result from S_DONE once the response register
// is free; an index of zero or out of range goes straight to S_DONE. Create: each slot from the
// hint is read (S_SCAN) and checked (S_SCHK), wrapping once to slot 1; full gives STATUS_FULL.
// Not ready until the result is issued. Reset: a clearing pass zeroes every count and generation;
// no word is accepted during it. Depends on ght_pkg, ght_if, ght_ram and ght_step_unit.
module generational_handle_table_unit import ght_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	ght_req_if.sink          req,
	ght_rsp_if.source        rsp
);

	localparam int AW = $clog2(SLOTS);
	localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);
	localparam logic [CFG_W-1:0] CAP_MAX = CFG_W'((SLOTS < CAP_LIMIT) ? SLOTS : CAP_LIMIT);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_SCHK,
		S_HRD,
		S_HCHK,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       clr_q;
	logic [CFG_W-1:0]    slots_in_use_q;
	logic [CFG_W-1:0]    hint_q;
	logic [ACT_W-1:0]    live_q;
	logic [CFG_W-1:0]    p_q;
	logic                phase_q;
	logic [CFG_W-1:0]    slot_q;
	kind_t               kind_q;
	logic [GEN_W-1:0]    gen_q;
	logic [PAY_W-1:0]    payload_q;
	status_t             res_status_q;
	logic [GEN_W-1:0]    res_gen_q;
	logic [CNT_W-1:0]    res_cnt_q;
	logic [PAY_W-1:0]    res_pay_q;
	logic                meta_wr_q;
	logic                create_ok_q;
	logic                rel_zero_q;

	logic                rsp_valid_q;
	status_t             rsp_status_q;
	logic [IDX_W-1:0]    rsp_idx_q;
	logic [GEN_W-1:0]    rsp_gen_q;
	logic [CNT_W-1:0]    rsp_cnt_q;
	logic [PAY_W-1:0]    rsp_pay_q;
	logic [ACT_W-1:0]    rsp_act_q;

	logic [CFG_W-1:0]    cap;
	logic [CFG_W-1:0]    req_idx;
	logic                accept;
	logic                done_fire;
	logic [ACT_W-1:0]    live_next;
	logic                meta_we;
	logic                pay_we;
	logic [AW-1:0]       ram_addr;
	logic [META_W-1:0]   meta_wdata;
	logic [META_W-1:0]   meta_rdata;
	logic [PAY_W-1:0]    pay_rdata;
	logic [GEN_W-1:0]    rd_gen;
	logic [CNT_W-1:0]    rd_cnt;
	logic                handle_match;
	step_req_t           step_cmd;
	step_rsp_t           step_res;

	assign cap       = (slots_in_use_q > CAP_MAX) ? CAP_MAX : slots_in_use_q;
	assign req_idx   = CFG_W'(req.handle_index);
	assign accept    = req.valid && req.ready;
	assign done_fire = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);
	assign rd_gen    = meta_rdata[META_W-1:CNT_W];
	assign rd_cnt    = meta_rdata[CNT_W-1:0];
	assign handle_match = (rd_gen == gen_q) && (rd_cnt != '0);

	always_comb begin
		live_next = live_q;
		if (done_fire && create_ok_q) begin
			live_next = live_q + ACT_W'(1);
		end else if (done_fire && rel_zero_q) begin
			live_next = live_q - ACT_W'(1);
		end
	end

	always_comb begin
		step_cmd.op = STEP_PASS;
		step_cmd.a  = '0;
		case (state_q)
			S_SCHK: begin
				step_cmd.op = STEP_INC;
				step_cmd.a  = (rd_cnt == '0) ? rd_gen : CNT_W'(p_q);
			end
			S_HCHK: begin
				step_cmd.a = rd_cnt;
				case (kind_q)
					KIND_ADD_REF: step_cmd.op = STEP_INC_SAT;
					KIND_RELEASE: step_cmd.op = STEP_DEC;
					default:      step_cmd.op = STEP_PASS;
				endcase
			end
			S_DONE: begin
				step_cmd.op = STEP_INC;
				step_cmd.a  = CNT_W'(slot_q);
			end
			default: begin
				step_cmd.op = STEP_PASS;
			end
		endcase
	end

	ght_step_unit u_step (
		.cmd (step_cmd),
		.res (step_res)
	);

	always_comb begin
		meta_we    = 1'b0;
		pay_we     = 1'b0;
		meta_wdata = {res_gen_q, res_cnt_q};
		ram_addr   = AW'(slot_q);
		case (state_q)
			S_CLEAR: begin
				meta_we    = 1'b1;
				meta_wdata = '0;
				ram_addr   = clr_q;
			end
			S_SCAN: begin
				ram_addr = AW'(p_q);
			end
			S_DONE: begin
				meta_we = done_fire && meta_wr_q;
				pay_we  = done_fire && create_ok_q;
			end
			default: begin
				ram_addr = AW'(slot_q);
			end
		endcase
	end

	ght_ram #(.WIDTH(META_W), .DEPTH(SLOTS)) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.addr  (ram_addr),
		.wdata (meta_wdata),
		.rdata (meta_rdata)
	);

	ght_ram #(.WIDTH(PAY_W), .DEPTH(SLOTS)) u_pay_ram (
		.clk   (clk),
		.we    (pay_we),
		.addr  (ram_addr),
		.wdata (payload_q),
		.rdata (pay_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			slots_in_use_q <= CFG_RESET;
			hint_q         <= HINT_RESET;
			live_q         <= '0;
			p_q            <= '0;
			phase_q        <= 1'b0;
			slot_q         <= '0;
			kind_q         <= KIND_CREATE;
			gen_q          <= '0;
			payload_q      <= '0;
			res_status_q   <= STATUS_OK;
			res_gen_q      <= '0;
			res_cnt_q      <= '0;
			res_pay_q      <= '0;
			meta_wr_q      <= 1'b0;
			create_ok_q    <= 1'b0;
			rel_zero_q     <= 1'b0;
			rsp_valid_q    <= 1'b0;
			rsp_status_q   <= STATUS_OK;
			rsp_idx_q      <= '0;
			rsp_gen_q      <= '0;
			rsp_cnt_q      <= '0;
			rsp_pay_q      <= '0;
			rsp_act_q      <= '0;
		end else begin
			if (cfg_we) begin
				slots_in_use_q <= cfg_wdata;
			end
			if (rsp_valid_q && rsp.ready && !done_fire) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_SLOT) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						kind_q       <= kind_t'(req.kind);
						gen_q        <= req.handle_generation;
						payload_q    <= req.payload_id;
						slot_q       <= req_idx;
						p_q          <= hint_q;
						phase_q      <= 1'b0;
						res_status_q <= STATUS_OK;
						res_gen_q    <= '0;
						res_cnt_q    <= '0;
						res_pay_q    <= '0;
						meta_wr_q    <= 1'b0;
						create_ok_q  <= 1'b0;
						rel_zero_q   <= 1'b0;
						if (kind_t'(req.kind) == KIND_CREATE) begin
							state_q <= S_SCAN;
						end else if (req_idx == '0 || req_idx >= cap) begin
							res_status_q <= STATUS_INVALID;
							slot_q       <= '0;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_HRD;
						end
					end
				end
				S_SCAN: begin
					if (!phase_q) begin
						if (p_q >= cap) begin
							phase_q <= 1'b1;
							p_q     <= CFG_W'(1);
						end else begin
							state_q <= S_SCHK;
						end
					end else if (p_q >= hint_q || p_q >= cap) begin
						res_status_q <= STATUS_FULL;
						slot_q       <= '0;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_SCHK;
					end
				end
				S_SCHK: begin
					if (rd_cnt == '0) begin
						slot_q      <= p_q;
						res_gen_q   <= step_res.y;
						res_cnt_q   <= CNT_W'(1);
						res_pay_q   <= payload_q;
						meta_wr_q   <= 1'b1;
						create_ok_q <= 1'b1;
						state_q     <= S_DONE;
					end else begin
						p_q     <= step_res.y[CFG_W-1:0];
						state_q <= S_SCAN;
					end
				end
				S_HRD: begin
					state_q <= S_HCHK;
				end
				S_HCHK: begin
					if (handle_match) begin
						res_gen_q  <= rd_gen;
						res_cnt_q  <= step_res.y;
						res_pay_q  <= step_res.zero ? '0 : pay_rdata;
						meta_wr_q  <= (kind_q != KIND_LOOKUP);
						rel_zero_q <= (kind_q == KIND_RELEASE) && step_res.zero;
					end else begin
						res_status_q <= STATUS_INVALID;
						slot_q       <= '0;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (done_fire) begin
						if (create_ok_q) begin
							hint_q <= step_res.y[CFG_W-1:0];
						end else if (rel_zero_q && slot_q < hint_q) begin
							hint_q <= slot_q;
						end
						live_q       <= live_next;
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= res_status_q;
						rsp_idx_q    <= slot_q[IDX_W-1:0];
						rsp_gen_q    <= res_gen_q;
						rsp_cnt_q    <= res_cnt_q;
						rsp_pay_q    <= res_pay_q;
						rsp_act_q    <= live_next;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready             = (state_q == S_IDLE);
	assign rsp.valid             = rsp_valid_q;
	assign rsp.status            = rsp_status_q;
	assign rsp.result_index      = rsp_idx_q;
	assign rsp.result_generation = rsp_gen_q;
	assign rsp.ref_count         = rsp_cnt_q;
	assign rsp.payload_out       = rsp_pay_q;
	assign rsp.active_count      = rsp_act_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request accepted while a word is in progress");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("response raised outside the completion step");

	a_ok_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == STATUS_OK |-> rsp.result_index != '0)
		else $error("successful response names the reserved slot");

	a_meta_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		meta_we |-> state_q == S_CLEAR || state_q == S_DONE)
		else $error("slot table written outside clear or completion");

	a_payload_with_meta: assert property (@(posedge clk) disable iff (!arst_n)
		pay_we |-> meta_we && create_ok_q)
		else $error("payload written without a matching create");

endmodule

// ----- tb/ght_tb_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard for the generational handle table: keeps its own copy of the slot table
// and predicts one result word per request word. Depends on ght_pkg.
package ght_tb_pkg;
	import ght_pkg::*;

	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] index;
		logic [GEN_W-1:0] generation;
		logic [CNT_W-1:0] count;
		logic [PAY_W-1:0] payload;
		logic [ACT_W-1:0] active;
	} handle_result_t;

	class handle_table_scoreboard;
		logic [CNT_W-1:0] refs [SLOTS_DEF];
		logic [GEN_W-1:0] gens [SLOTS_DEF];
		logic [PAY_W-1:0] payloads [SLOTS_DEF];
		int unsigned      hint;
		logic [ACT_W-1:0] live;
		int unsigned      size_reg;
		handle_result_t   pending [$];
		int               requests;
		int               results;
		int               failures;

		function new();
			foreach (refs[i]) begin
				refs[i] = '0;
				gens[i] = '0;
				payloads[i] = '0;
			end
			hint = HINT_RESET;
			live = '0;
			size_reg = CFG_RESET;
			requests = 0;
			results = 0;
			failures = 0;
		endfunction

		function void set_size(logic [CFG_W-1:0] slots);
			size_reg = slots;
		endfunction

		function int unsigned usable();
			return (size_reg < SLOTS_DEF) ? size_reg : SLOTS_DEF;
		endfunction

		function bit handle_valid(int unsigned idx, logic [GEN_W-1:0] gen);
			if (idx == 0 || idx >= usable())
				return 1'b0;
			return (gens[idx] == gen) && (refs[idx] != '0);
		endfunction

		function int unsigned find_free_slot();
			int unsigned cap;
			cap = usable();
			for (int unsigned i = hint; i < cap; i++) begin
				if (refs[i] == '0) begin
					hint = i + 1;
					return i;
				end
			end
			for (int unsigned i = 1; i < hint && i < cap; i++) begin
				if (refs[i] == '0) begin
					hint = i + 1;
					return i;
				end
			end
			return 0;
		endfunction

		function void note_request(kind_t kind, logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen,
			logic [PAY_W-1:0] pay);
			handle_result_t want;
			int unsigned    slot;
			want = '0;
			want.status = STATUS_OK;
			requests++;
			if (kind == KIND_CREATE) begin
				slot = find_free_slot();
				if (slot == 0) begin
					want.status = STATUS_FULL;
				end else begin
					payloads[slot] = pay;
					refs[slot] = CNT_W'(1);
					gens[slot] = gens[slot] + 1'b1;
					live = live + 1'b1;
					want.index = IDX_W'(slot);
					want.generation = gens[slot];
					want.count = CNT_W'(1);
					want.payload = pay;
				end
			end else if (!handle_valid(idx, gen)) begin
				want.status = STATUS_INVALID;
			end else begin
				case (kind)
					KIND_ADD_REF: begin
						if (refs[idx] != '1)
							refs[idx] = refs[idx] + 1'b1;
					end
					KIND_RELEASE: begin
						refs[idx] = refs[idx] - 1'b1;
						if (refs[idx] == '0) begin
							live = live - 1'b1;
							if (idx < hint)
								hint = idx;
						end
					end
					default: ;
				endcase
				want.index = idx;
				want.generation = gens[idx];
				want.count = refs[idx];
				want.payload = (refs[idx] != '0) ? payloads[idx] : '0;
			end
			want.active = live;
			pending.push_back(want);
		endfunction

		function string show(handle_result_t r);
			return $sformatf("st=%0d idx=%0d gen=%0d cnt=%0d pay=%h act=%0d",
				r.status, r.index, r.generation, r.count, r.payload, r.active);
		endfunction

		function void note_failure(string msg);
			failures++;
			if (failures <= 10)
				$display("handle result error: %s", msg);
		endfunction

		function void check_response(handle_result_t got);
			handle_result_t want;
			results++;
			if (pending.size() == 0) begin
				note_failure($sformatf("word %0d arrived with nothing pending: %s",
					results, show(got)));
				return;
			end
			want = pending.pop_front();
			if (got !== want)
				note_failure($sformatf("word %0d expected %s, got %s",
					results, show(want), show(got)));
		endfunction
	endclass

endpackage

// ----- tb/generational_handle_table_unit_test.sv -----
`timescale 1ns / 100ps
// Top level of the handle table testbench: clock, reset, request driver and result monitor.
// Depends on ght_pkg, ght_if, ght_tb_pkg and the generational_handle_table_unit RTL.
module generational_handle_table_unit_test;
	import ght_pkg::*;
	import ght_tb_pkg::*;

	localparam int CYCLE_LIMIT = 5_000_000;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;
	int               src_idle_pct = 15;
	int               sink_idle_pct = 55;
	int               cycles;
	int               block_sizes [11] = '{64, 7, 2, 127, 33, 16, 64, 12, 48, 3, 40};

	handle_table_scoreboard sb = new();

	ght_req_if req_ch();
	ght_rsp_if rsp_ch();

	generational_handle_table_unit #(.SLOTS(SLOTS_DEF)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic send_word(input kind_t kind, input logic [IDX_W-1:0] index,
		input logic [GEN_W-1:0] generation, input logic [PAY_W-1:0] payload);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= kind;
		req_ch.handle_index <= index;
		req_ch.handle_generation <= generation;
		req_ch.payload_id <= payload;
		do begin
			@(posedge clk);
		end while (req_ch.ready !== 1'b1);
		sb.note_request(kind, index, generation, payload);
	endtask

	task automatic write_size(input logic [CFG_W-1:0] slots);
		req_ch.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= slots;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_size(slots);
	endtask

	// result monitor and receiver stalls
	initial begin
		handle_result_t got;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got.status = status_t'(rsp_ch.status);
				got.index = rsp_ch.result_index;
				got.generation = rsp_ch.result_generation;
				got.count = rsp_ch.ref_count;
				got.payload = rsp_ch.payload_out;
				got.active = rsp_ch.active_count;
				sb.check_response(got);
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	initial begin
		int          pick;
		int          kind_pick;
		int          slot;
		int unsigned cap;
		int          live_slots [$];

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= CFG_RESET;
		req_ch.valid <= 1'b0;
		req_ch.kind <= KIND_CREATE;
		req_ch.handle_index <= '0;
		req_ch.handle_generation <= '0;
		req_ch.payload_id <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset size, then small, shrunk, zero, one and oversize tables
		send_word(KIND_LOOKUP, 0, 0, 0);
		send_word(KIND_LOOKUP, 5, 0, '1);
		send_word(KIND_CREATE, '1, '1, '1);
		send_word(KIND_CREATE, 0, 0, 0);
		send_word(KIND_LOOKUP, 1, sb.gens[1], 0);
		send_word(KIND_ADD_REF, 1, sb.gens[1], 0);
		send_word(KIND_LOOKUP, 1, ~sb.gens[1], 0);
		send_word(KIND_RELEASE, 1, sb.gens[1], 0);
		send_word(KIND_RELEASE, 1, sb.gens[1], 0);
		send_word(KIND_LOOKUP, 1, sb.gens[1], 0);
		send_word(KIND_CREATE, 0, 0, 32'hA5A5_5A5A);
		write_size(4);
		repeat (3) send_word(KIND_CREATE, IDX_W'($urandom), GEN_W'($urandom), $urandom);
		send_word(KIND_LOOKUP, '1, '1, 0);
		send_word(KIND_ADD_REF, 4, sb.gens[4], 0);
		write_size(2);
		send_word(KIND_LOOKUP, 2, sb.gens[2], 0);
		send_word(KIND_CREATE, 0, 0, $urandom);
		write_size(0);
		send_word(KIND_CREATE, 0, 0, $urandom);
		send_word(KIND_LOOKUP, 1, sb.gens[1], 0);
		write_size(1);
		send_word(KIND_CREATE, 0, 0, $urandom);
		send_word(KIND_RELEASE, 1, sb.gens[1], 0);
		write_size(127);
		send_word(KIND_LOOKUP, 3, sb.gens[3], 0);
		send_word(KIND_RELEASE, 2, sb.gens[2], 0);

		// random: creates and operations on live handles, some stale handles and raw noise
		block_sizes[9] = $urandom_range(3, 127);
		for (int blk = 0; blk < 11; blk++) begin
			if (blk == 4) begin
				src_idle_pct = 55;
				sink_idle_pct = 15;
			end
			if (blk == 8) begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			write_size(CFG_W'(block_sizes[blk]));
			repeat (100) begin
				live_slots.delete();
				cap = sb.usable();
				for (int i = 1; i < cap; i++)
					if (sb.refs[i] != '0)
						live_slots.push_back(i);
				pick = $urandom_range(0, 99);
				if (pick < 12) begin
					send_word(kind_t'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 63)),
						GEN_W'($urandom), $urandom);
				end else if (pick < 20 && live_slots.size() != 0) begin
					slot = live_slots[$urandom_range(0, live_slots.size() - 1)];
					send_word(kind_t'($urandom_range(1, 3)), IDX_W'(slot),
						sb.gens[slot] + 16'($urandom_range(1, 65535)), $urandom);
				end else if (pick < 50 || live_slots.size() == 0) begin
					send_word(KIND_CREATE, IDX_W'($urandom_range(0, 63)), GEN_W'($urandom),
						$urandom);
				end else begin
					slot = live_slots[$urandom_range(0, live_slots.size() - 1)];
					kind_pick = $urandom_range(0, 99);
					send_word((kind_pick < 20) ? KIND_ADD_REF :
						(kind_pick < 70) ? KIND_RELEASE : KIND_LOOKUP,
						IDX_W'(slot), sb.gens[slot], $urandom);
				end
			end
		end

		req_ch.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d request words, %0d result words, %0d failures", sb.requests, sb.results,
			sb.failures);
		$display("covered sizes 0 to 127, full and shrunk tables, %0s",
			"stale handles and raw request noise under both stall patterns");
		if (sb.failures == 0 && sb.pending.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/ght_pkg.sv
rtl/ght_if.sv
rtl/ght_ram.sv
rtl/ght_step_unit.sv
rtl/generational_handle_table_unit.sv
tb/ght_tb_pkg.sv
tb/generational_handle_table_unit_test.sv
